// ===== hw/rtl/blc_pkg.sv =====
// ----------------------------------------------------------------------------
// blc_pkg
// Shared types and constants of the beam chaser pattern generator.
// ----------------------------------------------------------------------------
package blc_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned LenW   = 10;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ColorW = 3 * ChanW;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [ChanW-1:0] LevelMax = 8'd255;

  // register indexes
  localparam logic [2:0] RegBeamColor   = 3'd0;
  localparam logic [2:0] RegMoveBack    = 3'd1;
  localparam logic [2:0] RegFadeHeadOn  = 3'd2;
  localparam logic [2:0] RegFadeTailOn  = 3'd3;
  localparam logic [2:0] RegBodyLength  = 3'd4;
  localparam logic [2:0] RegGapLength   = 3'd5;
  localparam logic [2:0] RegHeadLength  = 3'd6;
  localparam logic [2:0] RegTailLength  = 3'd7;

  // ramp step divider: two quotient bits per cycle over eight bits
  localparam int unsigned DivBitsPerStep = 2;
  localparam logic [1:0]  DivLastStep    = 2'd3;

  typedef enum logic [1:0] {
    SegRise,
    SegBody,
    SegFall,
    SegGap
  } seg_kind_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkLevel,
    BkDim
  } back_state_e;

  typedef struct packed {
    logic [ColorW-1:0] beam_color;
    logic              move_backward;
    logic              fade_head_on;
    logic              fade_tail_on;
    logic [LenW-1:0]   body_length;
    logic [LenW-1:0]   gap_length;
    logic [LenW-1:0]   head_length;
    logic [LenW-1:0]   tail_length;
  } cfg_t;

  typedef struct packed {
    seg_kind_e       kind;
    logic [LenW-1:0] idx;
    logic [LenW-1:0] len;
    logic            last;
  } pix_req_t;

endpackage

// ===== hw/rtl/blc_front.sv =====
// ----------------------------------------------------------------------------
// blc_front
// Accepts pixel requests, tracks frame offset and pattern position, and
// classifies each pixel into its pattern segment.
// ----------------------------------------------------------------------------
module blc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  blc_pkg::cfg_t     cfg_i,
  input  logic              cfg_wr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              frame_end_i,
  output logic              push_o,
  output blc_pkg::pix_req_t req_o,
  input  logic              q_full_i
);
  import blc_pkg::*;

  logic [PosW-1:0] offset_q, offset_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] rise_len, fall_len, body_len, gap_len;
  logic [PosW-1:0] bnd_body, bnd_fall, bnd_gap, size;
  logic [PosW-1:0] pos_inc, off_step;

  always_comb begin
    body_len = {{(PosW-LenW){1'b0}}, cfg_i.body_length};
    gap_len  = {{(PosW-LenW){1'b0}}, cfg_i.gap_length};
    if (cfg_i.move_backward) begin
      rise_len = cfg_i.fade_head_on ? {{(PosW-LenW){1'b0}}, cfg_i.head_length} : '0;
      fall_len = cfg_i.fade_tail_on ? {{(PosW-LenW){1'b0}}, cfg_i.tail_length} : '0;
    end else begin
      rise_len = cfg_i.fade_tail_on ? {{(PosW-LenW){1'b0}}, cfg_i.tail_length} : '0;
      fall_len = cfg_i.fade_head_on ? {{(PosW-LenW){1'b0}}, cfg_i.head_length} : '0;
    end
    bnd_body = rise_len;
    bnd_fall = bnd_body + body_len;
    bnd_gap  = bnd_fall + fall_len;
    size     = bnd_gap + gap_len;
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // segment of the current pixel
  always_comb begin
    req_o.last = frame_end_i;
    if (pos_q < bnd_body) begin
      req_o.kind = SegRise;
      req_o.idx  = pos_q[LenW-1:0];
      req_o.len  = rise_len[LenW-1:0];
    end else if (pos_q < bnd_fall) begin
      req_o.kind = SegBody;
      req_o.idx  = '0;
      req_o.len  = '0;
    end else if (pos_q < bnd_gap) begin
      req_o.kind = SegFall;
      req_o.idx  = pos_q[LenW-1:0] - bnd_fall[LenW-1:0];
      req_o.len  = fall_len[LenW-1:0];
    end else begin
      req_o.kind = SegGap;
      req_o.idx  = '0;
      req_o.len  = '0;
    end
  end

  // position and offset update
  always_comb begin
    pos_inc = (pos_q + 1'b1 == size) ? '0 : pos_q + 1'b1;
    if (cfg_i.move_backward) begin
      off_step = (offset_q + 1'b1 == size) ? '0 : offset_q + 1'b1;
    end else begin
      off_step = (offset_q == '0) ? size - 1'b1 : offset_q - 1'b1;
    end
    offset_d = offset_q;
    pos_d    = pos_q;
    if (cfg_wr_i) begin
      offset_d = '0;
      pos_d    = '0;
    end else if (push_o) begin
      if (size == '0) begin
        offset_d = '0;
        pos_d    = '0;
      end else if (frame_end_i) begin
        offset_d = off_step;
        pos_d    = off_step;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      pos_q    <= '0;
    end else begin
      offset_q <= offset_d;
      pos_q    <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/blc_queue.sv =====
// ----------------------------------------------------------------------------
// blc_queue
// Two-entry request queue between the classifier and the color unit.
// ----------------------------------------------------------------------------
module blc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  blc_pkg::pix_req_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output blc_pkg::pix_req_t pop_data_o
);
  import blc_pkg::*;

  pix_req_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/blc_back.sv =====
// ----------------------------------------------------------------------------
// blc_back
// Color unit: ramp step division, fade level and channel dimming, with an
// output register toward the pixel stream.
// ----------------------------------------------------------------------------
module blc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  blc_pkg::cfg_t              cfg_i,
  input  logic                       q_valid_i,
  input  blc_pkg::pix_req_t          q_data_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [blc_pkg::ColorW-1:0] out_color_o,
  output logic                       out_last_o
);
  import blc_pkg::*;

  back_state_e       state_q, state_d;
  pix_req_t          req_q;
  logic [LenW:0]     divisor_q;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [ChanW-1:0]  dvd_q, dvd_d;
  logic [ChanW-1:0]  quot_q, quot_d;
  logic [1:0]        cnt_q;
  logic [ChanW-1:0]  level_q;
  logic              out_valid_q;
  logic [ColorW-1:0] out_color_q;
  logic              out_last_q;

  logic              load, div_en, level_en, out_load;
  logic              out_free;
  logic [LenW+ChanW:0] prod;
  logic [ChanW:0]      lvl1;
  logic [2*ChanW:0]    dim_r, dim_g, dim_b;
  logic [ColorW-1:0]   color_d;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_color_o = out_color_q;
  assign out_last_o  = out_last_q;

  // two restoring division steps a cycle
  always_comb begin
    logic [LenW:0] trial;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    for (int i = 0; i < DivBitsPerStep; i++) begin
      trial = {rem_d, dvd_d[ChanW-1]};
      dvd_d = {dvd_d[ChanW-2:0], 1'b0};
      if (trial >= divisor_q) begin
        trial  = trial - divisor_q;
        quot_d = {quot_d[ChanW-2:0], 1'b1};
      end else begin
        quot_d = {quot_d[ChanW-2:0], 1'b0};
      end
      rem_d = trial[LenW-1:0];
    end
  end

  assign prod = ({1'b0, req_q.idx} + 1'b1) * quot_q;

  always_comb begin
    lvl1  = {1'b0, level_q} + 1'b1;
    dim_r = cfg_i.beam_color[23:16] * lvl1;
    dim_g = cfg_i.beam_color[15:8] * lvl1;
    dim_b = cfg_i.beam_color[7:0] * lvl1;
    case (req_q.kind)
      SegBody: color_d = cfg_i.beam_color;
      SegGap:  color_d = '0;
      default: color_d = {dim_r[15:8], dim_g[15:8], dim_b[15:8]};
    endcase
  end

  always_comb begin
    state_d  = state_q;
    load     = 1'b0;
    div_en   = 1'b0;
    level_en = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          load    = 1'b1;
          state_d = (q_data_i.kind == SegRise || q_data_i.kind == SegFall) ? BkDiv : BkDim;
        end
      end
      BkDiv: begin
        div_en = 1'b1;
        if (cnt_q == DivLastStep) begin
          state_d = BkLevel;
        end
      end
      BkLevel: begin
        level_en = 1'b1;
        state_d  = BkDim;
      end
      BkDim: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  assign q_pop_o = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q     <= q_data_i;
      divisor_q <= {1'b0, q_data_i.len} + 1'b1;
      rem_q     <= '0;
      dvd_q     <= LevelMax;
      quot_q    <= '0;
    end else if (div_en) begin
      rem_q  <= rem_d;
      dvd_q  <= dvd_d;
      quot_q <= quot_d;
    end
    if (level_en) begin
      level_q <= (req_q.kind == SegRise) ? prod[ChanW-1:0] : LevelMax - prod[ChanW-1:0];
    end
    if (out_load) begin
      out_color_q <= color_d;
      out_last_q  <= req_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q <= 2'd0;
      end else if (div_en) begin
        cnt_q <= cnt_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/led_beam_chaser_pattern.sv =====
// ----------------------------------------------------------------------------
// led_beam_chaser_pattern
// Moving beam pattern generator for an LED strip: fade ramps, solid body
// and black gap, one pixel color per request.
// ----------------------------------------------------------------------------
// color unit steps: body and gap pixels go straight to dimming; ramp pixels
// pass ramp step division and the fade level step first
// one pixel at a time: the color unit takes a new request only when idle
// reset: control state, config, offset and position clear; no clearing pass
// ----------------------------------------------------------------------------
module led_beam_chaser_pattern (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // frame_end
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [blc_pkg::ColorW-1:0] m_axis_tdata, // red_level, green_level, blue_level
  output logic                      m_axis_tlast,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [blc_pkg::AddrW-1:0] paddr,
  input  logic [blc_pkg::DataW-1:0] pwdata,
  output logic [blc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import blc_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic              cfg_wr;
  logic [2:0]        reg_idx;
  logic              push, q_full, q_pop, q_valid;
  pix_req_t          push_req, pop_req;
  logic [ColorW-1:0] out_color;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        RegBeamColor:  cfg_d.beam_color    = pwdata[ColorW-1:0];
        RegMoveBack:   cfg_d.move_backward = pwdata[0];
        RegFadeHeadOn: cfg_d.fade_head_on  = pwdata[0];
        RegFadeTailOn: cfg_d.fade_tail_on  = pwdata[0];
        RegBodyLength: cfg_d.body_length   = pwdata[LenW-1:0];
        RegGapLength:  cfg_d.gap_length    = pwdata[LenW-1:0];
        RegHeadLength: cfg_d.head_length   = pwdata[LenW-1:0];
        RegTailLength: cfg_d.tail_length   = pwdata[LenW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegBeamColor:  prdata = {{(DataW-ColorW){1'b0}}, cfg_q.beam_color};
      RegMoveBack:   prdata = {{(DataW-1){1'b0}}, cfg_q.move_backward};
      RegFadeHeadOn: prdata = {{(DataW-1){1'b0}}, cfg_q.fade_head_on};
      RegFadeTailOn: prdata = {{(DataW-1){1'b0}}, cfg_q.fade_tail_on};
      RegBodyLength: prdata = {{(DataW-LenW){1'b0}}, cfg_q.body_length};
      RegGapLength:  prdata = {{(DataW-LenW){1'b0}}, cfg_q.gap_length};
      RegHeadLength: prdata = {{(DataW-LenW){1'b0}}, cfg_q.head_length};
      RegTailLength: prdata = {{(DataW-LenW){1'b0}}, cfg_q.tail_length};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  blc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_wr_i    (cfg_wr),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .frame_end_i (s_axis_tdata[0]),
    .push_o      (push),
    .req_o       (push_req),
    .q_full_i    (q_full)
  );

  blc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_req),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_req)
  );

  blc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_req),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_color_o (out_color),
    .out_last_o  (m_axis_tlast)
  );

  // red in the low byte on the stream
  assign m_axis_tdata = {out_color[7:0], out_color[15:8], out_color[23:16]};

endmodule

// ===== test/led_beam_chaser_pattern_test.sv =====
// ----------------------------------------------------------------------------
// led_beam_chaser_pattern_test
// Drives pixel requests into the beam chaser while random stalls hit both
// stream sides, reprograms the pattern over APB between bursts, and checks
// every returned pixel against scripted colors or a cycle-free beam model.
// ----------------------------------------------------------------------------
module led_beam_chaser_pattern_test;
  import blc_pkg::*;

  localparam int unsigned SegmentMax   = 1023;
  localparam int unsigned ItemTarget   = 600;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned ScriptLen    = 43;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
  } pixel_t;

  typedef enum logic {RowPixel, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              frame_end;
    logic              typed;
    logic [ColorW-1:0] want;
    logic [2:0]        idx;
    logic [DataW-1:0]  value;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // frame_end
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [ColorW-1:0] m_axis_tdata;   // red_level, green_level, blue_level
  logic              m_axis_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  cfg_t          beam_cfg;
  logic [PosW-1:0] strip_offset;
  logic [PosW-1:0] pattern_pos;
  pixel_t        expected_pixels [$];
  pixel_t        got_pixel;
  pixel_t        want_pixel;
  int unsigned   mismatch_count = 0;
  int unsigned   pixels_seen    = 0;
  int unsigned   pixels_sent    = 0;
  int unsigned   cycle_count    = 0;
  bit            idling_on      = 1'b1;
  bit            hold_request   = 1'b0;

  row_t script [ScriptLen] = '{
    '{RowPixel, 1'b0, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowPixel, 1'b1, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegBeamColor,  32'hFFFF_FFFF},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegBodyLength, 32'hABCD_E401},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegGapLength,  32'h0000_0001},
    '{RowPixel, 1'b0, 1'b1, 24'hFFFFFF, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowPixel, 1'b1, 1'b1, 24'hFFFFFF, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    // reverse direction
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegMoveBack,   32'h0000_0001},
    '{RowPixel, 1'b1, 1'b1, 24'hFFFFFF, RegBeamColor,  32'h0},
    '{RowPixel, 1'b1, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'hFFFFFF, RegBeamColor,  32'h0},
    // one pixel ramps on both ends
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegFadeTailOn, 32'h0000_0001},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegTailLength, 32'h0000_0001},
    '{RowPixel, 1'b0, 1'b1, 24'hFFFFFF, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'h808080, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegFadeHeadOn, 32'hFFFF_FFFF},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegHeadLength, 32'h0000_0001},
    '{RowPixel, 1'b0, 1'b1, 24'h7F7F7F, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'hFFFFFF, RegBeamColor,  32'h0},
    '{RowPixel, 1'b1, 1'b1, 24'h808080, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'hFFFFFF, RegBeamColor,  32'h0},
    // longest segments, zero ramp step, offset wrap
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegBeamColor,  32'h5AFF_0080},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegMoveBack,   32'h0000_0002},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegBodyLength, 32'h0000_03FF},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegGapLength,  32'hFFFF_FFFF},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegHeadLength, 32'h0000_03FF},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegTailLength, 32'h0000_03FF},
    '{RowPixel, 1'b1, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowPixel, 1'b1, 1'b0, 24'h000000, RegBeamColor,  32'h0},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegGapLength,  32'hFFFF_FC00},
    '{RowPixel, 1'b1, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'hFF0080, RegBeamColor,  32'h0},
    '{RowPixel, 1'b0, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    // fades off, then an empty pattern
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegFadeHeadOn, 32'h0000_0000},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegFadeTailOn, 32'h0000_0000},
    '{RowPixel, 1'b1, 1'b1, 24'hFF0080, RegBeamColor,  32'h0},
    '{RowWrite, 1'b0, 1'b0, 24'h000000, RegBodyLength, 32'h0000_0000},
    '{RowPixel, 1'b0, 1'b1, 24'h000000, RegBeamColor,  32'h0},
    '{RowPixel, 1'b1, 1'b1, 24'h000000, RegBeamColor,  32'h0}
  };

  led_beam_chaser_pattern DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // beam pattern model

  function automatic int unsigned clipped(int unsigned len);
    return (len > SegmentMax) ? SegmentMax : len;
  endfunction

  function automatic int unsigned lead_ramp_len();
    if (beam_cfg.move_backward) begin
      return beam_cfg.fade_head_on ? clipped(beam_cfg.head_length) : 0;
    end
    return beam_cfg.fade_tail_on ? clipped(beam_cfg.tail_length) : 0;
  endfunction

  function automatic int unsigned trail_ramp_len();
    if (beam_cfg.move_backward) begin
      return beam_cfg.fade_tail_on ? clipped(beam_cfg.tail_length) : 0;
    end
    return beam_cfg.fade_head_on ? clipped(beam_cfg.head_length) : 0;
  endfunction

  function automatic logic [ColorW-1:0] scaled_color(int unsigned level);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    r = (beam_cfg.beam_color[23:16] * (level + 1)) >> 8;
    g = (beam_cfg.beam_color[15:8] * (level + 1)) >> 8;
    b = (beam_cfg.beam_color[7:0] * (level + 1)) >> 8;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [ColorW-1:0] pattern_color(int unsigned p);
    int unsigned lead;
    int unsigned body;
    int unsigned trail;
    lead  = lead_ramp_len();
    body  = clipped(beam_cfg.body_length);
    trail = trail_ramp_len();
    if (p < lead) begin
      return scaled_color((p + 1) * (255 / (lead + 1)));
    end
    p -= lead;
    if (p < body) begin
      return beam_cfg.beam_color;
    end
    p -= body;
    if (p < trail) begin
      return scaled_color(255 - (p + 1) * (255 / (trail + 1)));
    end
    return '0;
  endfunction

  // color of the next requested pixel, advancing position and frame offset
  function automatic pixel_t chase_pixel(logic frame_end);
    int unsigned size;
    int unsigned pos;
    int unsigned off;
    logic [ColorW-1:0] rgb;
    pixel_t px;
    size = lead_ramp_len() + clipped(beam_cfg.body_length) + trail_ramp_len()
           + clipped(beam_cfg.gap_length);
    rgb = '0;
    if (size == 0) begin
      strip_offset = '0;
      pattern_pos  = '0;
    end else begin
      pos = pattern_pos % size;
      off = strip_offset % size;
      rgb = pattern_color(pos);
      if (frame_end) begin
        if (beam_cfg.move_backward) begin
          off = (off + 1) % size;
        end else begin
          off = (off != 0) ? off - 1 : size - 1;
        end
        strip_offset = off[PosW-1:0];
        pattern_pos  = off[PosW-1:0];
      end else begin
        strip_offset = off[PosW-1:0];
        pos          = (pos + 1) % size;
        pattern_pos  = pos[PosW-1:0];
      end
    end
    px.red   = rgb[23:16];
    px.green = rgb[15:8];
    px.blue  = rgb[7:0];
    px.last  = frame_end;
    return px;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    if (!idling_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      return LenW'($urandom_range(0, 6));
    end else if (roll < 90) begin
      return LenW'($urandom_range(7, 40));
    end else if (roll < 97) begin
      return LenW'($urandom_range(0, 1023));
    end
    return LenW'(SegmentMax);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("pixel %0d: %s got %0h expected %0h", pixels_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [DataW-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegBeamColor:  beam_cfg.beam_color    = value[ColorW-1:0];
      RegMoveBack:   beam_cfg.move_backward = value[0];
      RegFadeHeadOn: beam_cfg.fade_head_on  = value[0];
      RegFadeTailOn: beam_cfg.fade_tail_on  = value[0];
      RegBodyLength: beam_cfg.body_length   = value[LenW-1:0];
      RegGapLength:  beam_cfg.gap_length    = value[LenW-1:0];
      RegHeadLength: beam_cfg.head_length   = value[LenW-1:0];
      RegTailLength: beam_cfg.tail_length   = value[LenW-1:0];
      default: ;
    endcase
    strip_offset = '0;
    pattern_pos  = '0;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_pixel(logic frame_end, logic typed, logic [ColorW-1:0] want_rgb);
    int unsigned gap;
    pixel_t px;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, frame_end};
    do @(posedge clk_i); while (!s_axis_tready);
    px = chase_pixel(frame_end);
    if (typed) begin
      px.red   = want_rgb[23:16];
      px.green = want_rgb[15:8];
      px.blue  = want_rgb[7:0];
    end
    expected_pixels.push_back(px);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    int unsigned n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        n = idle_len();
        if (n != 0) begin
          m_axis_tready <= 1'b0;
          repeat (n) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_pixel.red   = m_axis_tdata[7:0];
      got_pixel.green = m_axis_tdata[15:8];
      got_pixel.blue  = m_axis_tdata[23:16];
      got_pixel.last  = m_axis_tlast;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", got_pixel, 0);
      end else begin
        want_pixel = expected_pixels.pop_front();
        if (got_pixel.red !== want_pixel.red) begin
          report_mismatch("red_level", got_pixel.red, want_pixel.red);
        end
        if (got_pixel.green !== want_pixel.green) begin
          report_mismatch("green_level", got_pixel.green, want_pixel.green);
        end
        if (got_pixel.blue !== want_pixel.blue) begin
          report_mismatch("blue_level", got_pixel.blue, want_pixel.blue);
        end
        if (got_pixel.last !== want_pixel.last) begin
          report_mismatch("last_pixel", got_pixel.last, want_pixel.last);
        end
      end
      pixels_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned burst;
    int unsigned frame_len;
    int unsigned roll;
    logic [DataW-1:0] junk;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    beam_cfg      = '0;
    strip_offset  = '0;
    pattern_pos   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == RowWrite) begin
        write_reg(script[i].idx, script[i].value);
      end else begin
        send_pixel(script[i].frame_end, script[i].typed, script[i].want);
      end
    end

    phase = 0;
    while (pixels_sent < ItemTarget) begin
      phase++;
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 9) < 6) begin
          junk = $urandom;
          case (r[2:0])
            RegBeamColor: begin
              roll = $urandom_range(0, 9);
              if (roll == 0) begin
                junk[ColorW-1:0] = '0;
              end else if (roll == 1) begin
                junk[ColorW-1:0] = '1;
              end
            end
            RegBodyLength, RegGapLength, RegHeadLength, RegTailLength: begin
              junk[LenW-1:0] = rand_len();
            end
            default: ;
          endcase
          write_reg(r[2:0], junk);
        end
      end
      idling_on = ($urandom_range(0, 3) != 0);
      frame_len = $urandom_range(1, 16);
      burst     = $urandom_range(10, 50);
      for (int i = 0; i < burst; i++) begin
        if (i == burst / 2) begin
          if (phase == 2) begin
            hold_request = 1'b1;
          end else if (phase == 3) begin
            wait_drained();
          end
        end
        send_pixel($urandom_range(1, frame_len) == 1, 1'b0, '0);
      end
      wait_drained();
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
